FILE: design/fasi_pkg.sv
// Fan airflow safety interlock: shared types, register indexes and reset values.
// No dependencies; imported by fasi_update, fan_airflow_safety_interlock and the dv files.
package fasi_pkg;

	localparam int SpeedW   = 16;
	localparam int TempW    = 8;
	localparam int MsW      = 16;
	localparam int DriveW   = 10;
	localparam int SustainW = 24;
	localparam int LowAirW  = 25;
	localparam int TallyW   = 16;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;

	localparam int InDataW  = 56;
	localparam int OutDataW = 32;

	localparam logic [SpeedW-1:0]   DerateSpeedRst = 16'd1500;
	localparam logic [SpeedW-1:0]   CutoffSpeedRst = 16'd800;
	localparam logic [TempW-1:0]    CoolTempRst    = 8'd60;
	localparam logic [SustainW-1:0] SustainTimeRst = 24'd2000;
	localparam logic [DriveW-1:0]   DerateCapRst   = 10'd500;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DERATE_SPEED = 3'd0,
		CFG_CUTOFF_SPEED = 3'd1,
		CFG_COOL_TEMP    = 3'd2,
		CFG_SUSTAIN_TIME = 3'd3,
		CFG_DERATE_CAP   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_DERATE = 2'd1,
		MODE_CUTOFF = 2'd2
	} mode_t;

	typedef struct packed {
		logic [SpeedW-1:0]       derate_speed;
		logic [SpeedW-1:0]       cutoff_speed;
		logic signed [TempW-1:0] cool_temp;
		logic [SustainW-1:0]     sustain_time;
		logic [DriveW-1:0]       derate_cap;
	} cfg_t;

	typedef struct packed {
		logic                    reading_ok;
		logic [SpeedW-1:0]       fan_speed;
		logic signed [TempW-1:0] temperature;
		logic [MsW-1:0]          elapsed_ms;
		logic [DriveW-1:0]       drive_request;
	} item_t;

	typedef struct packed {
		mode_t               mode;
		logic [LowAirW-1:0]  low_air_time;
		logic [TallyW-1:0]   cutoff_tally;
	} state_t;

	typedef struct packed {
		logic [1:0]        interlock_mode;
		logic [DriveW-1:0] limited_drive;
		logic [TallyW-1:0] cutoff_events;
	} result_t;

endpackage

FILE: design/fasi_update.sv
// Fan airflow safety interlock: one-tick mode/timer/tally update and drive limit.
// Purely combinational; depends on fasi_pkg.
module fasi_update
	import fasi_pkg::*;
(
	input  cfg_t    cfg,
	input  item_t   item,
	input  state_t  cur,
	output state_t  nxt,
	output result_t res
);

	logic [LowAirW:0]   low_sum;
	logic [LowAirW-1:0] low_sat;
	logic               release_ok;
	mode_t              speed_mode;

	always_comb begin
		low_sum    = {1'b0, cur.low_air_time} + (LowAirW+1)'(item.elapsed_ms);
		low_sat    = low_sum[LowAirW] ? '1 : low_sum[LowAirW-1:0];
		release_ok = item.reading_ok && (item.fan_speed >= cfg.derate_speed)
			&& (item.temperature <= cfg.cool_temp);
		speed_mode = (item.fan_speed < cfg.derate_speed) ? MODE_DERATE : MODE_NORMAL;
	end

	// next state
	always_comb begin
		nxt = cur;
		case (cur.mode)
			MODE_CUTOFF: begin
				// latched: timer frozen until release
				if (release_ok) begin
					nxt.mode         = MODE_NORMAL;
					nxt.low_air_time = '0;
				end
			end
			default: begin
				if (!item.reading_ok) begin
					nxt.mode         = MODE_CUTOFF;
					nxt.low_air_time = '0;
					nxt.cutoff_tally = cur.cutoff_tally + 1'b1;
				end else if (item.fan_speed < cfg.cutoff_speed) begin
					if (low_sat >= LowAirW'(cfg.sustain_time)) begin
						nxt.mode         = MODE_CUTOFF;
						nxt.low_air_time = '0;
						nxt.cutoff_tally = cur.cutoff_tally + 1'b1;
					end else begin
						nxt.mode         = speed_mode;
						nxt.low_air_time = low_sat;
					end
				end else begin
					nxt.mode         = speed_mode;
					nxt.low_air_time = '0;
				end
			end
		endcase
	end

	// drive limit by new mode
	always_comb begin
		res.interlock_mode = nxt.mode;
		res.cutoff_events  = nxt.cutoff_tally;
		case (nxt.mode)
			MODE_NORMAL: res.limited_drive = item.drive_request;
			MODE_DERATE: res.limited_drive = (item.drive_request > cfg.derate_cap)
				? cfg.derate_cap : item.drive_request;
			default:     res.limited_drive = '0;
		endcase
	end

endmodule

FILE: design/fan_airflow_safety_interlock.sv
// Fan airflow safety interlock: top level with stream ports and config registers.
// Depends on fasi_pkg and fasi_update.

// One beat in, one beat out. Each input beat carries a sensor-valid flag, fan
// speed (rpm), temperature (signed degrees C), ms since the previous beat and a
// drive request (per mille). The block moves between normal, derate and latched
// cutoff: an invalid reading, or fan speed below cutoff_speed accumulated for
// sustain_time ms, trips cutoff; cutoff releases only on a valid reading at or
// above derate_speed and at or below cool_temp, and that release beat reports
// normal. Speed below derate_speed gives derate. The output beat carries the new
// mode, the drive request limited by that mode (passed in normal, capped at
// derate_cap in derate, zero in cutoff) and a 16-bit wrapping count of cutoff
// entries. The accept edge loads the input register; the beat then moves into the
// result register, and output valid rises, once that register is free or draining;
// one beat is accepted every cycle while the output side takes beats, since the
// mode, timer and tally feedback closes through the combinational update logic
// between the input register and the result register. Config writes take
// effect on the next edge and are expected only while no beat is in flight.
module fan_airflow_safety_interlock
	import fasi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,

	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [15:0] fan_speed, [23:16] temperature, [39:24] elapsed_ms,
	// [49:40] drive_request, [55:50] zero
	input  logic [InDataW-1:0]  s_axis_tdata,
	// [0] reading_ok
	input  logic                s_axis_tuser,

	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [1:0] interlock_mode, [11:2] limited_drive, [27:12] cutoff_events, [31:28] zero
	output logic [OutDataW-1:0] m_axis_tdata
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.derate_speed <= DerateSpeedRst;
			cfg_q.cutoff_speed <= CutoffSpeedRst;
			cfg_q.cool_temp    <= CoolTempRst;
			cfg_q.sustain_time <= SustainTimeRst;
			cfg_q.derate_cap   <= DerateCapRst;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DERATE_SPEED: cfg_q.derate_speed <= cfg_data[SpeedW-1:0];
				CFG_CUTOFF_SPEED: cfg_q.cutoff_speed <= cfg_data[SpeedW-1:0];
				CFG_COOL_TEMP:    cfg_q.cool_temp    <= cfg_data[TempW-1:0];
				CFG_SUSTAIN_TIME: cfg_q.sustain_time <= cfg_data[SustainW-1:0];
				CFG_DERATE_CAP:   cfg_q.derate_cap   <= cfg_data[DriveW-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves into the result register when that register is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.reading_ok    <= s_axis_tuser;
			item_s1.fan_speed     <= s_axis_tdata[15:0];
			item_s1.temperature   <= s_axis_tdata[23:16];
			item_s1.elapsed_ms    <= s_axis_tdata[39:24];
			item_s1.drive_request <= s_axis_tdata[49:40];
		end
	end

	fasi_update u_update (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// interlock state commits once per beat, as the beat moves to stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= MODE_NORMAL;
			state_q.low_air_time <= '0;
			state_q.cutoff_tally <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0, res_s2.cutoff_events, res_s2.limited_drive,
		res_s2.interlock_mode};

	// timer is always clear while latched in cutoff
	a_cutoff_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_CUTOFF) |-> (state_q.low_air_time == '0))
		else $error("low-air timer nonzero in cutoff");

	// tally moves only on entry into cutoff
	a_tally_on_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (state_nxt.cutoff_tally != state_q.cutoff_tally)) |->
		(state_nxt.mode == MODE_CUTOFF && state_q.mode != MODE_CUTOFF))
		else $error("cutoff tally changed without cutoff entry");

	// state changes only when a beat commits
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("interlock state changed without a beat");

	// a cutoff result never drives the fan
	a_cutoff_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.interlock_mode == MODE_CUTOFF) |->
		(res_s2.limited_drive == '0))
		else $error("nonzero drive reported in cutoff");

	// reported tally follows the committed state
	a_result_tally: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_s2.cutoff_events == state_q.cutoff_tally))
		else $error("result tally differs from state");

endmodule

FILE: dv/interlock_checker.sv
// Checker for the fan airflow safety interlock: tracks config writes, predicts each output beat.
// Depends on fasi_pkg; instantiated beside the DUT by tb_fan_airflow_safety_interlock.
module interlock_checker
	import fasi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,
	input  logic                s_axis_tuser,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [OutDataW-1:0] m_axis_tdata,
	output int                  mismatches,
	output int                  in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	// register shadow
	logic [SpeedW-1:0]       derate_spd;
	logic [SpeedW-1:0]       cutoff_spd;
	logic signed [TempW-1:0] cool_lim;
	logic [SustainW-1:0]     sustain_lim;
	logic [DriveW-1:0]       cap_lim;

	// interlock state
	mode_t                   ilk_mode;
	logic [LowAirW-1:0]      low_air_ms;
	logic [TallyW-1:0]       trip_count;

	result_t                 predicted_beats[$];
	result_t                 want_beat;
	result_t                 new_beat;
	int                      miss_cnt;
	int                      out_cnt;

	task automatic trip();
		if (ilk_mode != MODE_CUTOFF)
			trip_count = trip_count + 1'b1;
		ilk_mode   = MODE_CUTOFF;
		low_air_ms = '0;
	endtask

	task automatic step_interlock(input logic ok, input logic [SpeedW-1:0] speed,
			input logic signed [TempW-1:0] temp, input logic [MsW-1:0] dt,
			input logic [DriveW-1:0] req, output result_t r);
		logic [LowAirW:0] sum;
		logic             tripped;
		tripped = 1'b0;
		if (ilk_mode == MODE_CUTOFF) begin
			// latched: only a good, cool, fast reading releases
			if (ok && speed >= derate_spd && temp <= cool_lim) begin
				ilk_mode   = MODE_NORMAL;
				low_air_ms = '0;
			end
		end else if (!ok) begin
			trip();
		end else begin
			if (speed < cutoff_spd) begin
				sum = low_air_ms + dt;
				if (sum > {LowAirW{1'b1}})
					low_air_ms = '1;
				else
					low_air_ms = sum[LowAirW-1:0];
				if (low_air_ms >= sustain_lim) begin
					trip();
					tripped = 1'b1;
				end
			end else begin
				low_air_ms = '0;
			end
			if (!tripped)
				ilk_mode = (speed < derate_spd) ? MODE_DERATE : MODE_NORMAL;
		end
		r.interlock_mode = ilk_mode;
		case (ilk_mode)
			MODE_NORMAL: r.limited_drive = req;
			MODE_DERATE: r.limited_drive = (req > cap_lim) ? cap_lim : req;
			default:     r.limited_drive = '0;
		endcase
		r.cutoff_events = trip_count;
	endtask

	task automatic note_miss(input string what, input int want, input int got);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("%0t: output beat %0d, %s: expected %0d, got %0d",
				$time, out_cnt, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			derate_spd  = DerateSpeedRst;
			cutoff_spd  = CutoffSpeedRst;
			cool_lim    = CoolTempRst;
			sustain_lim = SustainTimeRst;
			cap_lim     = DerateCapRst;
			ilk_mode    = MODE_NORMAL;
			low_air_ms  = '0;
			trip_count  = '0;
			predicted_beats.delete();
			miss_cnt    = 0;
			out_cnt     = 0;
			mismatches <= 0;
			in_flight  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DERATE_SPEED: derate_spd  = cfg_data[SpeedW-1:0];
					CFG_CUTOFF_SPEED: cutoff_spd  = cfg_data[SpeedW-1:0];
					CFG_COOL_TEMP:    cool_lim    = cfg_data[TempW-1:0];
					CFG_SUSTAIN_TIME: sustain_lim = cfg_data[SustainW-1:0];
					CFG_DERATE_CAP:   cap_lim     = cfg_data[DriveW-1:0];
					default: ;
				endcase
			end
			// output first: a beat accepted this edge cannot be one that leaves this edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_beats.size() == 0) begin
					note_miss("unexpected beat, mode", -1, m_axis_tdata[1:0]);
				end else begin
					want_beat = predicted_beats.pop_front();
					if (m_axis_tdata[1:0] != want_beat.interlock_mode)
						note_miss("interlock_mode", want_beat.interlock_mode,
							m_axis_tdata[1:0]);
					if (m_axis_tdata[11:2] != want_beat.limited_drive)
						note_miss("limited_drive", want_beat.limited_drive,
							m_axis_tdata[11:2]);
					if (m_axis_tdata[27:12] != want_beat.cutoff_events)
						note_miss("cutoff_events", want_beat.cutoff_events,
							m_axis_tdata[27:12]);
				end
				out_cnt++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				step_interlock(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
					s_axis_tdata[39:24], s_axis_tdata[49:40], new_beat);
				predicted_beats.push_back(new_beat);
			end
			mismatches <= miss_cnt;
			in_flight  <= predicted_beats.size();
		end
	end

endmodule

FILE: dv/tb_fan_airflow_safety_interlock.sv
// Testbench top for the fan airflow safety interlock: clock, reset, stimulus and verdict.
// Depends on fasi_pkg, the DUT and interlock_checker, which does all prediction and compare.
module tb_fan_airflow_safety_interlock;
	import fasi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// generous: ~920 beats, with room for heavy stalls
	localparam int CycleLimit = 400000;
	localparam int SegBeats   = 150;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// [15:0] fan_speed, [23:16] temperature, [39:24] elapsed_ms,
	// [49:40] drive_request, [55:50] zero
	logic [InDataW-1:0]  s_axis_tdata;
	// [0] reading_ok
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// [1:0] interlock_mode, [11:2] limited_drive, [27:12] cutoff_events, [31:28] zero
	logic [OutDataW-1:0] m_axis_tdata;

	int mismatches;
	int in_flight;
	int cycle_count = 0;

	// idle percentages for the two sides, changed per phase
	int src_idle_pct;
	int sink_idle_pct;

	// what was last written to the registers, only used to aim stimulus
	int cur_ds;
	int cur_cs;
	int cur_cool;
	int cur_sus;
	int cur_cap;

	int seg;
	int n;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	fan_airflow_safety_interlock DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	interlock_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.in_flight     (in_flight)
	);

	// receiver back-pressure, a fresh coin every falling edge; none at sink_idle_pct 0
	always @(negedge clk) begin
		m_axis_tready <= (int'($urandom_range(0, 99)) >= sink_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// tvalid stays high on return so back-to-back beats need no extra NBA.
	task automatic send_beat(input logic ok, input int spd, input int tmp, input int dt,
			input int req);
		logic [SpeedW-1:0] f_spd;
		logic [TempW-1:0]  f_tmp;
		logic [MsW-1:0]    f_dt;
		logic [DriveW-1:0] f_req;
		f_spd = SpeedW'(spd);
		f_tmp = TempW'(tmp);
		f_dt  = MsW'(dt);
		f_req = DriveW'(req);
		while (int'($urandom_range(0, 99)) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= ok;
		s_axis_tdata  <= {6'b0, f_req, f_dt, f_tmp, f_spd};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Drop tvalid and hold off until every predicted beat has come back.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDataW'(val);
		@(negedge clk);
	endtask

	// Register settings per segment; first two and the reset set are the extremes
	// and the defaults, the last two invert the usual cutoff/derate order.
	task automatic apply_setting(input int k);
		case (k)
			0: begin cur_ds = 65535; cur_cs = 65535; cur_cool = -128; cur_sus = 0;        cur_cap = 0;    end
			1: begin cur_ds = 0;     cur_cs = 0;     cur_cool = 127;  cur_sus = 16777215; cur_cap = 1023; end
			2: begin cur_ds = 3000;  cur_cs = 1200;  cur_cool = 40;   cur_sus = 5000;     cur_cap = 1000; end
			3: begin cur_ds = 1500;  cur_cs = 800;   cur_cool = 60;   cur_sus = 2000;     cur_cap = 500;  end
			4: begin cur_ds = 500;   cur_cs = 2000;  cur_cool = -10;  cur_sus = 300;      cur_cap = 137;  end
			default: begin cur_ds = 1; cur_cs = 65534; cur_cool = 0;  cur_sus = 1;        cur_cap = 1001; end
		endcase
		cfg_write(CFG_DERATE_SPEED, cur_ds);
		cfg_write(CFG_CUTOFF_SPEED, cur_cs);
		// negative temps go out sign-extended; only the low byte matters
		cfg_write(CFG_COOL_TEMP, cur_cool);
		cfg_write(CFG_SUSTAIN_TIME, cur_sus);
		cfg_write(CFG_DERATE_CAP, cur_cap);
		cfg_we <= 1'b0;
	endtask

	function automatic int near(input int base, input int spread, input int lo, input int hi);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	// One random beat aimed at the current thresholds. Most beats form the
	// useful sequences: low-airflow runs that build toward a trip, and cool,
	// fast readings that release a latched cutoff. The rest is boundary hits,
	// raw noise and invalid readings.
	task automatic send_random();
		int   pick;
		int   spd;
		int   tmp;
		int   dt;
		int   req;
		int   span;
		logic ok;
		pick = $urandom_range(0, 99);
		ok   = 1'b1;
		span = cur_sus / 3;
		if (span > 65535) span = 65535;
		dt   = $urandom_range(0, span);
		if ($urandom_range(0, 19) == 0) dt = 65535;
		tmp  = int'($urandom_range(0, 255)) - 128;
		if ($urandom_range(0, 9) == 0)
			req = $urandom_range(0, 1023);   // over-range requests too
		else if ($urandom_range(0, 3) == 0)
			req = near(cur_cap, 1, 0, 1023);
		else
			req = $urandom_range(0, 1000);
		spd = $urandom_range(0, 65535);

		if (pick < 40) begin
			// starved airflow
			if (cur_cs == 0)
				spd = 0;
			else if ($urandom_range(0, 1))
				spd = cur_cs - 1;
			else
				spd = $urandom_range(0, cur_cs - 1);
		end else if (pick < 70) begin
			// release candidate; a fifth of them land within one of the speed and temp limits
			if ($urandom_range(0, 4) == 0) begin
				spd = near(cur_ds, 1, 0, 65535);
				tmp = near(cur_cool, 1, -128, 127);
			end else begin
				spd = cur_ds + int'($urandom_range(0, 3));
				if (spd > 65535) spd = 65535;
				tmp = cur_cool - int'($urandom_range(0, 3));
				if (tmp < -128) tmp = -128;
			end
		end else if (pick < 85) begin
			spd = $urandom_range(0, 1) ? near(cur_ds, 2, 0, 65535) : near(cur_cs, 2, 0, 65535);
			tmp = near(cur_cool, 2, -128, 127);
		end else if (pick < 93) begin
			dt  = $urandom_range(0, 65535);
		end else begin
			ok  = 1'b0;
			dt  = $urandom_range(0, 65535);
		end
		send_beat(ok, spd, tmp, dt, req);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_DERATE_SPEED;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		src_idle_pct  = 19;
		sink_idle_pct = 63;
		cur_ds        = 1500;
		cur_cs        = 800;
		cur_cool      = 60;
		cur_sus       = 2000;
		cur_cap       = 500;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk at reset settings (derate 1500, cutoff 800, cool 60,
		// sustain 2000, cap 500).
		send_beat(1'b1, 65535,  127,     0, 1000);  // top speed, hot: plain normal
		send_beat(1'b1,  1000,   20,    10, 1023);  // derate, over-range request capped
		send_beat(1'b1,     0, -128,  1999,    0);  // low air, one ms short of trip
		send_beat(1'b1,   799,    0,     1,  700);  // reaches sustain: cutoff, tally 1
		send_beat(1'b1, 65535,   61,     5,  900);  // fast but too hot: stays latched
		send_beat(1'b1,  1499,   60,     5,  900);  // cool but too slow: stays latched
		send_beat(1'b0, 65535, -128,     5,  900);  // invalid while latched: no new count
		send_beat(1'b1,  1500,   60,     5, 1023);  // release at both limits, drive passes
		send_beat(1'b1,     0,    0, 65535,  300);  // one huge step trips at once
		send_beat(1'b1,  1500, -128,     0,  300);  // release again
		send_beat(1'b1,   100,    0,   100,  600);  // derate, low air 100
		send_beat(1'b1,   800,    0,   100,  600);  // at cutoff speed: timer clears
		send_beat(1'b1,   700,    0,  1950,  600);  // would trip without the clear
		send_beat(1'b0, 65535,  127, 65535, 1000);  // invalid reading trips
		send_beat(1'b0,     0, -128,     0,    0);  // invalid again, still latched
		send_beat(1'b1,  2000,    0,     3,  512);  // release to normal
		send_beat(1'b1,  1499,    0,     3,  499);  // derate below cap
		send_beat(1'b1,  1499,    0,     3,  501);  // derate just above cap

		// Random segments: new settings each, idling pattern changes every two.
		for (seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				src_idle_pct  = 63;
				sink_idle_pct = 19;
			end else if (seg == 4) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			wait_idle();
			apply_setting(seg);
			for (n = 0; n < SegBeats; n++) begin
				// mid-segment hold-off until the pipe is empty
				if (n == SegBeats / 2)
					wait_idle();
				send_random();
			end
		end

		wait_idle();
		// leave room for any stray beat
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/fasi_pkg.sv
design/fasi_update.sv
design/fan_airflow_safety_interlock.sv
dv/interlock_checker.sv
dv/tb_fan_airflow_safety_interlock.sv
